[rtl/core/fpcu_pkg.sv]
// Shared types, constants and fixed-point helpers for the FDTD pressure cell update.
package fpcu_pkg;

    localparam int WORD_W        = 32;
    localparam int PROD_W        = 64;
    localparam int FRAC_SHIFT    = 30;
    localparam int RND_W         = PROD_W - FRAC_SHIFT;
    localparam int WIDE_W        = 40;
    localparam int CARRIED_TERMS = 2;
    localparam int REG_IDX_W     = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [RND_W-1:0]  rnd_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_SUM     = 3'd0,
        REG_PRESSURE     = 3'd1,
        REG_GAIN_FIRST   = 3'd2,
        REG_GAIN_SECOND  = 3'd3,
        REG_DECAY_FIRST  = 3'd4,
        REG_DECAY_SECOND = 3'd5,
        REG_MEAN_FIRST   = 3'd6,
        REG_MEAN_SECOND  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        word_t gain_sum;
        word_t pressure;
        word_t gain_first;
        word_t gain_second;
        word_t decay_first;
        word_t decay_second;
        word_t mean_first;
        word_t mean_second;
    } coef_t;

    localparam wide_t WIDE_MAX = 40'sh007FFFFFFF;
    localparam wide_t WIDE_MIN = 40'shFF80000000;
    localparam word_t WORD_MAX = 32'sh7FFFFFFF;
    localparam word_t WORD_MIN = 32'sh80000000;

    function automatic word_t sat32(input wide_t v);
        word_t r;
        if (v > WIDE_MAX) begin
            r = WORD_MAX;
        end else if (v < WIDE_MIN) begin
            r = WORD_MIN;
        end else begin
            r = word_t'(v[WORD_W-1:0]);
        end
        return r;
    endfunction

    // Q2.30 x Q16.16 product back to Q16.16, round half up (floor after bias).
    function automatic rnd_t round_q30(input prod_t p);
        prod_t t;
        t = p + (prod_t'(1) <<< (FRAC_SHIFT - 1));
        return rnd_t'(t[PROD_W-1:FRAC_SHIFT]);
    endfunction

endpackage

[rtl/core/fpcu_div_stage.sv]
// First stage: velocity divergence, saturated, plus carried cell fields.
module fpcu_div_stage (
    input  logic                 aclk,
    input  logic                 en,
    input  fpcu_pkg::word_t      vx_low,
    input  fpcu_pkg::word_t      vx_high,
    input  fpcu_pkg::word_t      vy_low,
    input  fpcu_pkg::word_t      vy_high,
    input  fpcu_pkg::word_t      vz_low,
    input  fpcu_pkg::word_t      vz_high,
    input  fpcu_pkg::word_t      pressure_old,
    input  fpcu_pkg::word_t      relax_first_old,
    input  fpcu_pkg::word_t      relax_second_old,
    output fpcu_pkg::word_t      div_reg,
    output fpcu_pkg::word_t      pressure_old_reg,
    output fpcu_pkg::word_t      relax_old_reg [fpcu_pkg::CARRIED_TERMS]
);

    fpcu_pkg::wide_t div_sum;
    fpcu_pkg::word_t div_next;

    always_comb begin
        div_sum = (fpcu_pkg::wide_t'(vx_high) - fpcu_pkg::wide_t'(vx_low))
                + (fpcu_pkg::wide_t'(vy_high) - fpcu_pkg::wide_t'(vy_low))
                + (fpcu_pkg::wide_t'(vz_high) - fpcu_pkg::wide_t'(vz_low));
        div_next = fpcu_pkg::sat32(div_sum);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg          <= div_next;
            pressure_old_reg <= pressure_old;
            relax_old_reg[0] <= relax_first_old;
            relax_old_reg[1] <= relax_second_old;
        end
    end

endmodule

[rtl/core/fpcu_mul_array.sv]
// Row of registered 32x32 signed multipliers.
module fpcu_mul_array #(
    parameter int LANES = 4
) (
    input  logic            aclk,
    input  logic            en,
    input  fpcu_pkg::word_t a [LANES],
    input  fpcu_pkg::word_t b [LANES],
    output fpcu_pkg::prod_t prod_reg [LANES]
);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                prod_reg[i] <= fpcu_pkg::prod_t'(a[i]) * fpcu_pkg::prod_t'(b[i]);
            end
        end
    end

endmodule

[rtl/core/fpcu_offset_stage.sv]
// Third stage: relaxation targets and offsets, pressure base sum.
module fpcu_offset_stage (
    input  logic            aclk,
    input  logic            en,
    input  fpcu_pkg::prod_t prod_gain [fpcu_pkg::CARRIED_TERMS],
    input  fpcu_pkg::prod_t prod_scale,
    input  fpcu_pkg::prod_t prod_pres,
    input  fpcu_pkg::word_t pressure_old,
    input  fpcu_pkg::word_t relax_old [fpcu_pkg::CARRIED_TERMS],
    output fpcu_pkg::word_t target_reg [fpcu_pkg::CARRIED_TERMS],
    output fpcu_pkg::word_t offset_reg [fpcu_pkg::CARRIED_TERMS],
    output fpcu_pkg::wide_t base_reg
);

    fpcu_pkg::word_t target_next [fpcu_pkg::CARRIED_TERMS];
    fpcu_pkg::word_t offset_next [fpcu_pkg::CARRIED_TERMS];
    fpcu_pkg::wide_t base_next;

    always_comb begin
        for (int r = 0; r < fpcu_pkg::CARRIED_TERMS; r++) begin
            target_next[r] = fpcu_pkg::sat32(
                fpcu_pkg::wide_t'(fpcu_pkg::round_q30(prod_gain[r])));
            offset_next[r] = fpcu_pkg::sat32(
                fpcu_pkg::wide_t'(relax_old[r]) - fpcu_pkg::wide_t'(target_next[r]));
        end
        base_next = fpcu_pkg::wide_t'(pressure_old)
                  + fpcu_pkg::wide_t'(fpcu_pkg::round_q30(prod_scale))
                  - fpcu_pkg::wide_t'(fpcu_pkg::round_q30(prod_pres));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            target_reg <= target_next;
            offset_reg <= offset_next;
            base_reg   <= base_next;
        end
    end

endmodule

[rtl/core/fpcu_update_stage.sv]
// Last stage: new relaxation states and new pressure, saturated.
module fpcu_update_stage #(
    parameter int ACTIVE_TERMS = 2
) (
    input  logic            aclk,
    input  logic            en,
    input  fpcu_pkg::prod_t prod_decay [fpcu_pkg::CARRIED_TERMS],
    input  fpcu_pkg::prod_t prod_mean [fpcu_pkg::CARRIED_TERMS],
    input  fpcu_pkg::word_t target [fpcu_pkg::CARRIED_TERMS],
    input  fpcu_pkg::wide_t base,
    output fpcu_pkg::word_t pressure_reg,
    output fpcu_pkg::word_t fresh_reg [fpcu_pkg::CARRIED_TERMS]
);

    fpcu_pkg::word_t fresh_next [fpcu_pkg::CARRIED_TERMS];
    fpcu_pkg::wide_t pres_sum;
    fpcu_pkg::word_t pressure_next;

    always_comb begin
        pres_sum = base;
        for (int r = 0; r < fpcu_pkg::CARRIED_TERMS; r++) begin
            if (r < ACTIVE_TERMS) begin
                fresh_next[r] = fpcu_pkg::sat32(fpcu_pkg::wide_t'(target[r])
                    + fpcu_pkg::wide_t'(fpcu_pkg::round_q30(prod_decay[r])));
                pres_sum = pres_sum + fpcu_pkg::wide_t'(fpcu_pkg::round_q30(prod_mean[r]));
            end else begin
                // term switched off: state reads zero, no pressure contribution
                fresh_next[r] = '0;
            end
        end
        pressure_next = fpcu_pkg::sat32(pres_sum);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pressure_reg <= pressure_next;
            fresh_reg    <= fresh_next;
        end
    end

endmodule

[rtl/core/fdtd_pressure_cell_update_unit.sv]
// 5-stage register pipeline; empty stages absorb output stalls.
// Throughput: one cell per cycle unless the output stalls; stages are divergence,
// gain/scale multiply, target/offset, decay/mean multiply, final sums.
// Reset (aresetn, synchronous, active low) clears all stage valids and sets every
// coefficient register to zero; data registers are not reset.
module fdtd_pressure_cell_update_unit #(
    parameter int RELAX_TERMS = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vx_low, vx_high, vy_low, vy_high, vz_low, vz_high, pressure_old,
    // relax_first_old, relax_second_old (32 bits each, lowest first)
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pressure_new, relax_first_new, relax_second_new (32 bits each, lowest first)
    output logic [95:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int STAGES       = 5;
    localparam int ACTIVE_TERMS = (RELAX_TERMS > fpcu_pkg::CARRIED_TERMS)
                                ? fpcu_pkg::CARRIED_TERMS
                                : ((RELAX_TERMS < 0) ? 0 : RELAX_TERMS);
    localparam int W = fpcu_pkg::WORD_W;

    fpcu_pkg::coef_t     coef_reg;
    logic [STAGES-1:0]   valid_reg;
    logic [STAGES-1:0]   valid_next;
    logic [STAGES-1:0]   stage_en;

    // stage 1 outputs
    fpcu_pkg::word_t div_reg;
    fpcu_pkg::word_t pold1_reg;
    fpcu_pkg::word_t rold1_reg [fpcu_pkg::CARRIED_TERMS];
    // stage 2
    fpcu_pkg::word_t mul1_a [4];
    fpcu_pkg::word_t mul1_b [4];
    fpcu_pkg::prod_t mul1_reg [4];
    fpcu_pkg::word_t pold2_reg;
    fpcu_pkg::word_t rold2_reg [fpcu_pkg::CARRIED_TERMS];
    fpcu_pkg::prod_t prod_gain [fpcu_pkg::CARRIED_TERMS];
    // stage 3
    fpcu_pkg::word_t target3_reg [fpcu_pkg::CARRIED_TERMS];
    fpcu_pkg::word_t offset3_reg [fpcu_pkg::CARRIED_TERMS];
    fpcu_pkg::wide_t base3_reg;
    // stage 4
    fpcu_pkg::word_t mul2_a [4];
    fpcu_pkg::word_t mul2_b [4];
    fpcu_pkg::prod_t mul2_reg [4];
    fpcu_pkg::word_t target4_reg [fpcu_pkg::CARRIED_TERMS];
    fpcu_pkg::wide_t base4_reg;
    fpcu_pkg::prod_t prod_decay [fpcu_pkg::CARRIED_TERMS];
    fpcu_pkg::prod_t prod_mean [fpcu_pkg::CARRIED_TERMS];
    // stage 5
    fpcu_pkg::word_t pressure_reg;
    fpcu_pkg::word_t fresh_reg [fpcu_pkg::CARRIED_TERMS];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (fpcu_pkg::cfg_reg_t'(cfg_index))
                fpcu_pkg::REG_GAIN_SUM:     coef_reg.gain_sum     <= cfg_wdata;
                fpcu_pkg::REG_PRESSURE:     coef_reg.pressure     <= cfg_wdata;
                fpcu_pkg::REG_GAIN_FIRST:   coef_reg.gain_first   <= cfg_wdata;
                fpcu_pkg::REG_GAIN_SECOND:  coef_reg.gain_second  <= cfg_wdata;
                fpcu_pkg::REG_DECAY_FIRST:  coef_reg.decay_first  <= cfg_wdata;
                fpcu_pkg::REG_DECAY_SECOND: coef_reg.decay_second <= cfg_wdata;
                fpcu_pkg::REG_MEAN_FIRST:   coef_reg.mean_first   <= cfg_wdata;
                fpcu_pkg::REG_MEAN_SECOND:  coef_reg.mean_second  <= cfg_wdata;
            endcase
        end
    end

    // a stage loads when it is empty or the stage after it moves on
    always_comb begin
        stage_en[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[STAGES-1];

    fpcu_div_stage u_div (
        .aclk             (aclk),
        .en               (stage_en[0]),
        .vx_low           (s_tdata[0*W +: W]),
        .vx_high          (s_tdata[1*W +: W]),
        .vy_low           (s_tdata[2*W +: W]),
        .vy_high          (s_tdata[3*W +: W]),
        .vz_low           (s_tdata[4*W +: W]),
        .vz_high          (s_tdata[5*W +: W]),
        .pressure_old     (s_tdata[6*W +: W]),
        .relax_first_old  (s_tdata[7*W +: W]),
        .relax_second_old (s_tdata[8*W +: W]),
        .div_reg          (div_reg),
        .pressure_old_reg (pold1_reg),
        .relax_old_reg    (rold1_reg)
    );

    always_comb begin
        mul1_a[0] = div_reg;  mul1_b[0] = coef_reg.gain_first;
        mul1_a[1] = div_reg;  mul1_b[1] = coef_reg.gain_second;
        mul1_a[2] = div_reg;  mul1_b[2] = coef_reg.gain_sum;
        mul1_a[3] = div_reg;  mul1_b[3] = coef_reg.pressure;
    end

    fpcu_mul_array #(.LANES(4)) u_mul_gain (
        .aclk     (aclk),
        .en       (stage_en[1]),
        .a        (mul1_a),
        .b        (mul1_b),
        .prod_reg (mul1_reg)
    );

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            pold2_reg <= pold1_reg;
            rold2_reg <= rold1_reg;
        end
    end

    assign prod_gain[0] = mul1_reg[0];
    assign prod_gain[1] = mul1_reg[1];

    fpcu_offset_stage u_offset (
        .aclk         (aclk),
        .en           (stage_en[2]),
        .prod_gain    (prod_gain),
        .prod_scale   (mul1_reg[2]),
        .prod_pres    (mul1_reg[3]),
        .pressure_old (pold2_reg),
        .relax_old    (rold2_reg),
        .target_reg   (target3_reg),
        .offset_reg   (offset3_reg),
        .base_reg     (base3_reg)
    );

    always_comb begin
        mul2_a[0] = offset3_reg[0];  mul2_b[0] = coef_reg.decay_first;
        mul2_a[1] = offset3_reg[1];  mul2_b[1] = coef_reg.decay_second;
        mul2_a[2] = offset3_reg[0];  mul2_b[2] = coef_reg.mean_first;
        mul2_a[3] = offset3_reg[1];  mul2_b[3] = coef_reg.mean_second;
    end

    fpcu_mul_array #(.LANES(4)) u_mul_decay (
        .aclk     (aclk),
        .en       (stage_en[3]),
        .a        (mul2_a),
        .b        (mul2_b),
        .prod_reg (mul2_reg)
    );

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            target4_reg <= target3_reg;
            base4_reg   <= base3_reg;
        end
    end

    assign prod_decay[0] = mul2_reg[0];
    assign prod_decay[1] = mul2_reg[1];
    assign prod_mean[0]  = mul2_reg[2];
    assign prod_mean[1]  = mul2_reg[3];

    fpcu_update_stage #(.ACTIVE_TERMS(ACTIVE_TERMS)) u_update (
        .aclk         (aclk),
        .en           (stage_en[4]),
        .prod_decay   (prod_decay),
        .prod_mean    (prod_mean),
        .target       (target4_reg),
        .base         (base4_reg),
        .pressure_reg (pressure_reg),
        .fresh_reg    (fresh_reg)
    );

    assign m_tdata = {fresh_reg[1], fresh_reg[0], pressure_reg};

    // accepted transfer always lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted transfer did not enter stage 1");

    // with the output register empty the whole pipe can move
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    // a held middle stage keeps its item
    a_mid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[2] && !stage_en[2]) |=> valid_reg[2])
        else $error("stalled item dropped in stage 3");

    // an output is never taken from a stage that held nothing
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_en[4] && !valid_reg[3]) |=> !m_tvalid)
        else $error("output valid without a source item");

    a_inactive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (ACTIVE_TERMS < 2)) |-> (m_tdata[95:64] == '0))
        else $error("inactive relaxation term produced nonzero state");

endmodule

[bench/cell_update_checker.sv]
// Watches both channels of the pressure cell update unit, predicts each result and compares.
`timescale 1ns / 100ps

module cell_update_checker #(
    parameter int RELAX_TERMS = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    output int           mismatch_count,
    output int           cells_in_flight
);

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    // first member sits in the top bits, so fields are listed highest first
    typedef struct packed {
        fpcu_pkg::word_t relax_second_old;
        fpcu_pkg::word_t relax_first_old;
        fpcu_pkg::word_t pressure_old;
        fpcu_pkg::word_t vz_high;
        fpcu_pkg::word_t vz_low;
        fpcu_pkg::word_t vy_high;
        fpcu_pkg::word_t vy_low;
        fpcu_pkg::word_t vx_high;
        fpcu_pkg::word_t vx_low;
    } cell_in_t;

    typedef struct packed {
        fpcu_pkg::word_t relax_second_new;
        fpcu_pkg::word_t relax_first_new;
        fpcu_pkg::word_t pressure_new;
    } cell_out_t;

    fpcu_pkg::coef_t coefs;
    cell_out_t       expected_cells[$];
    cell_out_t       want;
    cell_out_t       got;

    initial begin
        mismatch_count  = 0;
        cells_in_flight = 0;
        coefs           = '0;
    end

    function automatic longint wide(input fpcu_pkg::word_t w);
        return longint'(w);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > SAT_HI) begin
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            return SAT_LO;
        end
        return v;
    endfunction

    // Q2.30 coefficient times Q16.16 value, round to nearest with ties upward
    function automatic longint scale_q30(input longint v, input fpcu_pkg::word_t c);
        longint p;
        p = v * wide(c) + (longint'(1) <<< 29);
        return p >>> 30;
    endfunction

    function automatic cell_out_t predict_cell(input cell_in_t c, input fpcu_pkg::coef_t k);
        longint          div;
        longint          tgt;
        longint          ofs;
        longint          acc;
        longint          pres;
        longint          old_state[2];
        longint          new_state[2];
        fpcu_pkg::word_t gain[2];
        fpcu_pkg::word_t decay[2];
        fpcu_pkg::word_t mean[2];
        int              terms;
        cell_out_t       r;
        terms = (RELAX_TERMS > 2) ? 2 : ((RELAX_TERMS < 0) ? 0 : RELAX_TERMS);
        gain[0]      = k.gain_first;
        gain[1]      = k.gain_second;
        decay[0]     = k.decay_first;
        decay[1]     = k.decay_second;
        mean[0]      = k.mean_first;
        mean[1]      = k.mean_second;
        old_state[0] = wide(c.relax_first_old);
        old_state[1] = wide(c.relax_second_old);

        div = (wide(c.vx_high) - wide(c.vx_low)) + (wide(c.vy_high) - wide(c.vy_low))
            + (wide(c.vz_high) - wide(c.vz_low));
        div = clamp32(div);

        acc = scale_q30(div, k.gain_sum);
        for (int t = 0; t < 2; t++) begin
            new_state[t] = 0;
            if (t < terms) begin
                tgt          = clamp32(scale_q30(div, gain[t]));
                ofs          = clamp32(old_state[t] - tgt);
                new_state[t] = clamp32(tgt + scale_q30(ofs, decay[t]));
                acc          = acc + scale_q30(ofs, mean[t]);
            end
        end
        pres = clamp32(wide(c.pressure_old) + acc - scale_q30(div, k.pressure));

        r.pressure_new     = fpcu_pkg::word_t'(pres);
        r.relax_first_new  = fpcu_pkg::word_t'(new_state[0]);
        r.relax_second_new = fpcu_pkg::word_t'(new_state[1]);
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input fpcu_pkg::word_t got_w,
                                 input fpcu_pkg::word_t want_w);
        if (got_w !== want_w) begin
            report_error($sformatf("%s got %0d, expected %0d", name, got_w, want_w));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            coefs = '0;
            expected_cells.delete();
        end else begin
            // retire before queuing; the pipeline never returns a cell in its own transfer cycle
            if (m_tvalid && m_tready) begin
                if (expected_cells.size() == 0) begin
                    report_error($sformatf("result transfer with no cell pending: %h", m_tdata));
                end else begin
                    want = expected_cells.pop_front();
                    got  = cell_out_t'(m_tdata);
                    compare_field("pressure_new", got.pressure_new, want.pressure_new);
                    compare_field("relax_first_new", got.relax_first_new, want.relax_first_new);
                    compare_field("relax_second_new", got.relax_second_new,
                                  want.relax_second_new);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_cells.push_back(predict_cell(cell_in_t'(s_tdata), coefs));
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    fpcu_pkg::REG_GAIN_SUM:     coefs.gain_sum     = cfg_wdata;
                    fpcu_pkg::REG_PRESSURE:     coefs.pressure     = cfg_wdata;
                    fpcu_pkg::REG_GAIN_FIRST:   coefs.gain_first   = cfg_wdata;
                    fpcu_pkg::REG_GAIN_SECOND:  coefs.gain_second  = cfg_wdata;
                    fpcu_pkg::REG_DECAY_FIRST:  coefs.decay_first  = cfg_wdata;
                    fpcu_pkg::REG_DECAY_SECOND: coefs.decay_second = cfg_wdata;
                    fpcu_pkg::REG_MEAN_FIRST:   coefs.mean_first   = cfg_wdata;
                    fpcu_pkg::REG_MEAN_SECOND:  coefs.mean_second  = cfg_wdata;
                    default: ;
                endcase
            end
        end
        cells_in_flight = expected_cells.size();
    end

endmodule

[bench/tb_fdtd_pressure_cell_update_unit.sv]
// Stimulus and verdict for the FDTD pressure cell update unit.
`timescale 1ns / 100ps

module tb_fdtd_pressure_cell_update_unit;

    localparam int TERMS         = 2;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASES        = 10;
    localparam int PHASE_CELLS   = 115;
    localparam int HOLD_PHASE    = 4;
    localparam int DIRECTED      = 8;

    typedef struct packed {
        fpcu_pkg::word_t relax_second_old;
        fpcu_pkg::word_t relax_first_old;
        fpcu_pkg::word_t pressure_old;
        fpcu_pkg::word_t vz_high;
        fpcu_pkg::word_t vz_low;
        fpcu_pkg::word_t vy_high;
        fpcu_pkg::word_t vy_low;
        fpcu_pkg::word_t vx_high;
        fpcu_pkg::word_t vx_low;
    } cell_in_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [95:0]  m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    int mismatch_count;
    int cells_in_flight;
    int burst_left = 0;
    int rx_mode    = 0;
    int rx_span    = 0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;

    always #4 aclk = ~aclk;

    fdtd_pressure_cell_update_unit #(.RELAX_TERMS(TERMS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    cell_update_checker #(.RELAX_TERMS(TERMS)) cell_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .cells_in_flight (cells_in_flight)
    );

    function automatic fpcu_pkg::word_t random_word();
        fpcu_pkg::word_t w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: return fpcu_pkg::WORD_MAX;
            1: return fpcu_pkg::WORD_MIN;
            2: return '0;
            3, 4, 5, 6, 7: return w >>> $urandom_range(4, 26);
            default: return w;
        endcase
    endfunction

    function automatic fpcu_pkg::word_t random_coef();
        fpcu_pkg::word_t w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: return fpcu_pkg::WORD_MAX;
            1: return fpcu_pkg::WORD_MIN;
            2: return '0;
            3, 4, 5, 6, 7: return w >>> $urandom_range(1, 12);
            default: return w;
        endcase
    endfunction

    function automatic cell_in_t random_cell();
        cell_in_t c;
        c.vx_low           = random_word();
        c.vx_high          = random_word();
        c.vy_low           = random_word();
        c.vy_high          = random_word();
        c.vz_low           = random_word();
        c.vz_high          = random_word();
        c.pressure_old     = random_word();
        c.relax_first_old  = random_word();
        c.relax_second_old = random_word();
        return c;
    endfunction

    function automatic cell_in_t directed_cell(input int k);
        cell_in_t c;
        c = '0;
        case (k)
            1: c = {9{fpcu_pkg::WORD_MAX}};
            2: c = {9{fpcu_pkg::WORD_MIN}};
            3: begin
                // divergence clips high
                c.vx_high = fpcu_pkg::WORD_MAX;
                c.vy_high = fpcu_pkg::WORD_MAX;
                c.vz_high = fpcu_pkg::WORD_MAX;
                c.vx_low  = fpcu_pkg::WORD_MIN;
                c.vy_low  = fpcu_pkg::WORD_MIN;
                c.vz_low  = fpcu_pkg::WORD_MIN;
            end
            4: begin
                // divergence clips low
                c.vx_low  = fpcu_pkg::WORD_MAX;
                c.vy_low  = fpcu_pkg::WORD_MAX;
                c.vz_low  = fpcu_pkg::WORD_MAX;
                c.vx_high = fpcu_pkg::WORD_MIN;
                c.vy_high = fpcu_pkg::WORD_MIN;
                c.vz_high = fpcu_pkg::WORD_MIN;
                c.pressure_old     = fpcu_pkg::WORD_MAX;
                c.relax_first_old  = fpcu_pkg::WORD_MIN;
                c.relax_second_old = fpcu_pkg::WORD_MAX;
            end
            5: begin
                // one LSB of divergence: half-way products round up
                c.vx_high          = 32'sd1;
                c.pressure_old     = 32'sh00010000;
                c.relax_first_old  = 32'sd1;
                c.relax_second_old = -32'sd1;
            end
            6: begin
                c.vx_low          = 32'sd1;
                c.pressure_old    = -32'sh00010000;
                c.relax_first_old = -32'sd1;
            end
            7: begin
                // large negative divergence against saturated states
                c.vx_low           = 32'sh40000000;
                c.vy_low           = 32'sh30000000;
                c.pressure_old     = fpcu_pkg::WORD_MIN;
                c.relax_first_old  = fpcu_pkg::WORD_MAX;
                c.relax_second_old = fpcu_pkg::WORD_MIN;
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic fpcu_pkg::coef_t nominal_coefs();
        fpcu_pkg::coef_t k;
        k.gain_sum     = 32'sh20000000;
        k.pressure     = 32'sh30000000;
        k.gain_first   = 32'sh0CCCCCCD;
        k.gain_second  = -32'sh08000000;
        k.decay_first  = 32'sh3999999A;
        k.decay_second = 32'sh20000000;
        k.mean_first   = 32'sh10000000;
        k.mean_second  = -32'sh04000000;
        return k;
    endfunction

    function automatic fpcu_pkg::coef_t phase_coefs(input int phase);
        fpcu_pkg::coef_t k;
        case (phase)
            0: k = {8{fpcu_pkg::WORD_MAX}};
            1: k = {8{fpcu_pkg::WORD_MIN}};
            2: k = {4{fpcu_pkg::WORD_MAX, fpcu_pkg::WORD_MIN}};
            3: k = nominal_coefs();
            default: begin
                k.gain_sum     = random_coef();
                k.pressure     = random_coef();
                k.gain_first   = random_coef();
                k.gain_second  = random_coef();
                k.decay_first  = random_coef();
                k.decay_second = random_coef();
                k.mean_first   = random_coef();
                k.mean_second  = random_coef();
            end
        endcase
        return k;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic offer_cell(input cell_in_t c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 4);
                default: gap = $urandom_range(5, 24);
            endcase
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (cells_in_flight != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input fpcu_pkg::cfg_reg_t idx, input fpcu_pkg::word_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic load_coefs(input fpcu_pkg::coef_t k);
        write_reg(fpcu_pkg::REG_GAIN_SUM, k.gain_sum);
        write_reg(fpcu_pkg::REG_PRESSURE, k.pressure);
        write_reg(fpcu_pkg::REG_GAIN_FIRST, k.gain_first);
        write_reg(fpcu_pkg::REG_GAIN_SECOND, k.gain_second);
        write_reg(fpcu_pkg::REG_DECAY_FIRST, k.decay_first);
        write_reg(fpcu_pkg::REG_DECAY_SECOND, k.decay_second);
        write_reg(fpcu_pkg::REG_MEAN_FIRST, k.mean_first);
        write_reg(fpcu_pkg::REG_MEAN_SECOND, k.mean_second);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_directed();
        for (int k = 0; k < DIRECTED; k++) begin
            offer_cell(directed_cell(k));
        end
    endtask

    // result side backpressure, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (rx_span == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_span = $urandom_range(8, 64);
            end
            rx_span--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 7) != 0);
                default: m_tready <= ((rx_span % 3) != 0);
            endcase
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // coefficients still at their reset value of zero
        run_directed();
        drain_results();
        load_coefs(nominal_coefs());
        run_directed();
        drain_results();
        load_coefs({8{fpcu_pkg::WORD_MAX}});
        run_directed();

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            load_coefs(phase_coefs(phase));
            if (phase == HOLD_PHASE) begin
                hold_req <= 1'b1;
            end
            repeat (PHASE_CELLS) offer_cell(random_cell());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && cells_in_flight == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
